@@ hw/rtl/tttr_pkg.sv @@
// ----------------------------------------------------------------------------
// tttr_pkg
// Shared types, constants and helper functions of the tap tempo clock tracker
// ----------------------------------------------------------------------------
package tttr_pkg;

    localparam int TIMER_BITS = 32;
    localparam int PERIOD_W   = 32;
    localparam int HOLD_W     = 32;
    localparam int SMALL_W    = 16;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CMP_W      = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;

    typedef logic [TIMER_BITS-1:0] timer_t;

    localparam timer_t TIMER_MAX = '1;

    localparam logic [HOLD_W-1:0]  HOLD_CLEAR_RESET   = HOLD_W'(2000);
    localparam logic [SMALL_W-1:0] SMALL_CHANGE_RESET = SMALL_W'(100);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOLD_CLEAR   = 2'd0,
        REG_FREE_RUNNING = 2'd1,
        REG_FALLBACK     = 2'd2,
        REG_SMALL_CHANGE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [HOLD_W-1:0]  hold_clear_ticks;
        logic               free_running;
        logic               fallback_to_tap;
        logic [SMALL_W-1:0] small_change_ticks;
    } cfg_t;

    typedef struct packed {
        logic button_level;
        logic ping_edge;
    } item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic                clock_bus;
        logic                tap_out;
        logic                period_updated;
        logic                force_jump;
        logic                small_change;
        logic                stop_request;
        logic                restart_now;
    } result_t;

    // pipeline handshake between the stages
    typedef struct packed {
        logic s1_valid;
        logic advance;
    } stage_ctrl_t;

    function automatic timer_t sat_inc(input timer_t t);
        return (t == TIMER_MAX) ? t : t + timer_t'(1);
    endfunction

    function automatic timer_t abs_diff(input timer_t a, input timer_t b);
        return (a > b) ? a - b : b - a;
    endfunction

endpackage

@@ hw/rtl/tttr_in_if.sv @@
// ----------------------------------------------------------------------------
// tttr_in_if
// Tick channel: button level and ping edge per beat
// ----------------------------------------------------------------------------
interface tttr_in_if;
    logic valid;
    logic ready;
    logic button_level;
    logic ping_edge;

    modport source (output valid, output button_level, output ping_edge, input ready);
    modport sink   (input valid, input button_level, input ping_edge, output ready);
endinterface

@@ hw/rtl/tttr_out_if.sv @@
// ----------------------------------------------------------------------------
// tttr_out_if
// Result channel: period, clock levels and event flags per beat
// ----------------------------------------------------------------------------
interface tttr_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] period;
    logic        clock_bus;
    logic        tap_out;
    logic        period_updated;
    logic        force_jump;
    logic        small_change;
    logic        stop_request;
    logic        restart_now;

    modport source (
        output valid, output period, output clock_bus, output tap_out,
        output period_updated, output force_jump, output small_change,
        output stop_request, output restart_now, input ready
    );
    modport sink (
        input valid, input period, input clock_bus, input tap_out,
        input period_updated, input force_jump, input small_change,
        input stop_request, input restart_now, output ready
    );
endinterface

@@ hw/rtl/tap_tempo_ping_clock_tracker_top.sv @@
// ----------------------------------------------------------------------------
// tap_tempo_ping_clock_tracker_top
// Tap tempo clock tracker with external ping sync
//
//   channel  | dir | handshake          | payload
//   ---------+-----+--------------------+-----------------------------------
//   in_ch    | in  | valid / ready      | button_level, ping_edge
//   out_ch   | out | valid / ready      | period, levels, event flags
//   cfg      | in  | cfg_wr_en          | cfg_index, cfg_data
//
// one beat per clock unless out_ch stalls; a beat passes the input register,
// one pass of tick logic and the result register on its way to out_ch
// reset clears all tracker state and loads the register defaults
// a stalled result holds the core; the input register still takes one beat
// ----------------------------------------------------------------------------
module tap_tempo_ping_clock_tracker_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [tttr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tttr_pkg::CFG_DATA_W-1:0]  cfg_data,
    tttr_in_if.sink                          in_ch,
    tttr_out_if.source                       out_ch
);

    tttr_pkg::cfg_t        cfg;
    tttr_pkg::item_t       item;
    tttr_pkg::result_t     result;
    tttr_pkg::stage_ctrl_t ctrl;
    logic                  out_can_take;

    tttr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (cfg_wr_en),
        .index (cfg_index),
        .data  (cfg_data),
        .cfg   (cfg)
    );

    tttr_in_stage u_in_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_ch        (in_ch),
        .out_can_take (out_can_take),
        .ctrl         (ctrl),
        .item         (item)
    );

    tttr_tick_core u_tick_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (ctrl.advance),
        .item   (item),
        .cfg    (cfg),
        .result (result)
    );

    tttr_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .result   (result),
        .can_take (out_can_take),
        .out_ch   (out_ch)
    );

endmodule

@@ hw/rtl/tttr_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// tttr_cfg_regs
// Configuration register file, write only
// ----------------------------------------------------------------------------
module tttr_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [tttr_pkg::CFG_IDX_W-1:0]      index,
    input  logic [tttr_pkg::CFG_DATA_W-1:0]     data,
    output tttr_pkg::cfg_t                      cfg
);

    tttr_pkg::cfg_t cfg_reg;
    tttr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (tttr_pkg::cfg_reg_t'(index))
                tttr_pkg::REG_HOLD_CLEAR:
                    cfg_next.hold_clear_ticks = data[tttr_pkg::HOLD_W-1:0];
                tttr_pkg::REG_FREE_RUNNING:
                    cfg_next.free_running = data[0];
                tttr_pkg::REG_FALLBACK:
                    cfg_next.fallback_to_tap = data[0];
                tttr_pkg::REG_SMALL_CHANGE:
                    cfg_next.small_change_ticks = data[tttr_pkg::SMALL_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_clear_ticks   <= tttr_pkg::HOLD_CLEAR_RESET;
            cfg_reg.free_running       <= 1'b0;
            cfg_reg.fallback_to_tap    <= 1'b0;
            cfg_reg.small_change_ticks <= tttr_pkg::SMALL_CHANGE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/tttr_in_stage.sv @@
// ----------------------------------------------------------------------------
// tttr_in_stage
// Input register holding one tick beat until the core takes it
// ----------------------------------------------------------------------------
module tttr_in_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    tttr_in_if.sink              in_ch,
    input  logic                 out_can_take,
    output tttr_pkg::stage_ctrl_t ctrl,
    output tttr_pkg::item_t      item
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    tttr_pkg::item_t item_reg;
    logic            advance;
    logic            take;

    assign advance     = s1_valid_reg && out_can_take;
    assign in_ch.ready = !s1_valid_reg || advance;
    assign take        = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.button_level <= in_ch.button_level;
            item_reg.ping_edge    <= in_ch.ping_edge;
        end
    end

    assign ctrl.s1_valid = s1_valid_reg;
    assign ctrl.advance  = advance;
    assign item          = item_reg;

endmodule

@@ hw/rtl/tttr_tick_core.sv @@
// ----------------------------------------------------------------------------
// tttr_tick_core
// Tracker state and the single-pass update for one tick
// ----------------------------------------------------------------------------
module tttr_tick_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  tttr_pkg::item_t   item,
    input  tttr_pkg::cfg_t    cfg,
    output tttr_pkg::result_t result
);

    tttr_pkg::timer_t clock_period_reg, clock_period_next;
    tttr_pkg::timer_t last_tap_interval_reg, last_tap_interval_next;
    tttr_pkg::timer_t tap_period_reg, tap_period_next;
    tttr_pkg::timer_t tap_in_timer_reg, tap_in_timer_next;
    tttr_pkg::timer_t tap_out_timer_reg, tap_out_timer_next;
    tttr_pkg::timer_t ping_timer_reg, ping_timer_next;
    tttr_pkg::timer_t ping_stamp_reg, ping_stamp_next;
    logic tap_mode_reg, tap_mode_next;
    logic tap_tick_seen_reg, tap_tick_seen_next;
    logic button_prev_reg, button_prev_next;
    logic bus_level_reg, bus_level_next;
    logic tap_level_reg, tap_level_next;

    tttr_pkg::timer_t now;
    tttr_pkg::timer_t prev;
    tttr_pkg::timer_t diff;
    tttr_pkg::timer_t phase;
    logic ping_valid;
    logic upd, jump, small_chg, stop, restart;

    always_comb
    begin
        clock_period_next      = clock_period_reg;
        last_tap_interval_next = last_tap_interval_reg;
        tap_period_next        = tap_period_reg;
        ping_stamp_next        = ping_stamp_reg;
        tap_mode_next          = tap_mode_reg;
        tap_tick_seen_next     = tap_tick_seen_reg;
        bus_level_next         = bus_level_reg;
        tap_level_next         = tap_level_reg;
        ping_valid = 1'b0;
        upd        = 1'b0;
        jump       = 1'b0;
        small_chg  = 1'b0;
        stop       = 1'b0;
        restart    = 1'b0;
        prev       = '0;
        diff       = '0;
        phase      = '0;

        tap_in_timer_next  = tttr_pkg::sat_inc(tap_in_timer_reg);
        tap_out_timer_next = tttr_pkg::sat_inc(tap_out_timer_reg);
        ping_timer_next    = tttr_pkg::sat_inc(ping_timer_reg);
        now                = tap_in_timer_next;

        // external ping
        if (item.ping_edge)
        begin
            ping_stamp_next = ping_timer_next;
            ping_valid      = 1'b1;
            bus_level_next  = 1'b1;
            ping_timer_next = '0;
            tap_mode_next   = 1'b0;
        end

        // tap button
        if (item.button_level)
        begin
            if (!button_prev_reg)
            begin
                tap_mode_next = 1'b1;
                if ((last_tap_interval_next != '0) &&
                    (tttr_pkg::abs_diff(last_tap_interval_next, now) <
                     (last_tap_interval_next >> 1)))
                begin
                    clock_period_next = (now >> 1) + (last_tap_interval_next >> 1);
                end
                else
                begin
                    clock_period_next      = now;
                    last_tap_interval_next = now;
                end
                tap_period_next    = clock_period_next;
                tap_in_timer_next  = '0;
                tap_out_timer_next = '0;
                upd  = 1'b1;
                jump = 1'b1;
            end
            else if (tttr_pkg::CMP_W'(now) > tttr_pkg::CMP_W'(cfg.hold_clear_ticks))
            begin
                if (tap_mode_next)
                begin
                    stop              = 1'b1;
                    clock_period_next = '0;
                    tap_mode_next     = 1'b0;
                end
                tap_period_next        = '0;
                last_tap_interval_next = '0;
                tap_out_timer_next     = '0;
            end
        end
        button_prev_next = item.button_level;

        // tap clock generator
        if (tap_period_next != '0)
        begin
            if (tap_out_timer_next >= tap_period_next)
            begin
                tap_out_timer_next = '0;
                if (tap_mode_next)
                begin
                    bus_level_next     = 1'b1;
                    tap_tick_seen_next = 1'b1;
                end
                tap_level_next = 1'b1;
            end
            else if (tap_out_timer_next >= (tap_period_next >> 1))
            begin
                tap_level_next = 1'b0;
            end
        end

        // period from ping, or ping timeout
        if (tap_tick_seen_next || ping_valid)
        begin
            if (ping_valid)
            begin
                prev              = clock_period_next;
                clock_period_next = ping_stamp_next;
                if (prev != '0)
                begin
                    diff = tttr_pkg::abs_diff(clock_period_next, prev);
                    if (diff > (prev >> 3))
                        jump = 1'b1;
                    else if (diff > tttr_pkg::timer_t'(cfg.small_change_ticks))
                        small_chg = 1'b1;
                end
            end
            ping_stamp_next    = '0;
            tap_tick_seen_next = 1'b0;
            if (!tap_mode_next)
                last_tap_interval_next = '0;
            upd = 1'b1;
        end
        else if ((clock_period_next != '0) && !cfg.free_running && !tap_mode_next)
        begin
            if ({1'b0, ping_timer_next} >= {clock_period_next, 1'b0})
            begin
                ping_timer_next = '0;
                if ((tap_period_next != '0) && cfg.fallback_to_tap)
                begin
                    tap_mode_next     = 1'b1;
                    clock_period_next = tap_period_next;
                    upd     = 1'b1;
                    restart = 1'b1;
                end
                else
                begin
                    stop              = 1'b1;
                    clock_period_next = '0;
                end
            end
        end

        // clock bus falls at half period
        if (clock_period_next != '0)
        begin
            phase = tap_mode_next ? tap_out_timer_next : ping_timer_next;
            if (phase >= (clock_period_next >> 1))
                bus_level_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_period_reg      <= '0;
            last_tap_interval_reg <= '0;
            tap_period_reg        <= '0;
            tap_in_timer_reg      <= '0;
            tap_out_timer_reg     <= '0;
            ping_timer_reg        <= '0;
            ping_stamp_reg        <= '0;
            tap_mode_reg          <= 1'b0;
            tap_tick_seen_reg     <= 1'b0;
            button_prev_reg       <= 1'b0;
            bus_level_reg         <= 1'b0;
            tap_level_reg         <= 1'b0;
        end
        else if (step)
        begin
            clock_period_reg      <= clock_period_next;
            last_tap_interval_reg <= last_tap_interval_next;
            tap_period_reg        <= tap_period_next;
            tap_in_timer_reg      <= tap_in_timer_next;
            tap_out_timer_reg     <= tap_out_timer_next;
            ping_timer_reg        <= ping_timer_next;
            ping_stamp_reg        <= ping_stamp_next;
            tap_mode_reg          <= tap_mode_next;
            tap_tick_seen_reg     <= tap_tick_seen_next;
            button_prev_reg       <= button_prev_next;
            bus_level_reg         <= bus_level_next;
            tap_level_reg         <= tap_level_next;
        end
    end

    assign result.period         = tttr_pkg::PERIOD_W'(clock_period_next);
    assign result.clock_bus      = bus_level_next;
    assign result.tap_out        = tap_level_next;
    assign result.period_updated = upd;
    assign result.force_jump     = jump;
    assign result.small_change   = small_chg;
    assign result.stop_request   = stop;
    assign result.restart_now    = restart;

    ping_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.ping_edge |=> ping_timer_reg == '0)
        else $error("ping beat did not clear the ping timer");

    tap_timer_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        tap_period_reg != '0 |-> tap_out_timer_reg < tap_period_reg)
        else $error("tap output timer reached the tap period");

    restart_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        step && restart |-> upd && !stop && tap_mode_next)
        else $error("restart without update or together with stop");

    stop_clears_period: assert property (@(posedge clk) disable iff (!rst_n)
        step && stop |=> clock_period_reg == '0 && !tap_mode_reg)
        else $error("stop left a running clock");

endmodule

@@ hw/rtl/tttr_out_stage.sv @@
// ----------------------------------------------------------------------------
// tttr_out_stage
// Result register towards the output channel
// ----------------------------------------------------------------------------
module tttr_out_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  tttr_pkg::stage_ctrl_t ctrl,
    input  tttr_pkg::result_t  result,
    output logic               can_take,
    tttr_out_if.source         out_ch
);

    logic              out_valid_reg;
    logic              out_valid_next;
    tttr_pkg::result_t result_reg;

    assign can_take = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.advance)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
            result_reg <= result;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.period         = result_reg.period;
    assign out_ch.clock_bus      = result_reg.clock_bus;
    assign out_ch.tap_out        = result_reg.tap_out;
    assign out_ch.period_updated = result_reg.period_updated;
    assign out_ch.force_jump     = result_reg.force_jump;
    assign out_ch.small_change   = result_reg.small_change;
    assign out_ch.stop_request   = result_reg.stop_request;
    assign out_ch.restart_now    = result_reg.restart_now;

endmodule
